// ----- rtl/rau_pkg.sv -----
// Shared types and codes for the rational arithmetic unit.
// No dependencies; used by every module of the block.
`default_nettype none
package rau_pkg;

  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_MUL = 3'd2;
  localparam logic [2:0] OP_DIV = 3'd3;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZDEN = 2'd1;
  localparam logic [1:0] ST_OVF  = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL_L, S_MUL_R, S_MUL_T, S_MUL_S, S_FORM, S_SIGN,
    S_GCD, S_DIVS, S_DIVT, S_FIN
  } state_t;

  typedef enum logic [1:0] {
    MS_LHS, MS_RHS, MS_T, MS_S
  } mul_sel_t;

  typedef struct packed {
    logic     load;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     form;
    logic     sign;
    logic     gcd_step;
    logic     gcd_fin;
    logic     div_step;
    logic     div_end_s;
    logic     div_end_t;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic arith;
    logic zs;
    logic zt;
    logic gcd_done;
    logic div_last;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

// ----- rtl/rau_datapath.sv -----
// Datapath: shared multiplier, sum/sign stage, binary gcd, restoring divider, output register.
// Depends on rau_pkg.
`default_nettype none
module rau_datapath #(
  parameter int WORD_BITS = 32
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire rau_pkg::cmd_t      cmd,
  output rau_pkg::sts_t           sts,
  input  wire logic [2:0]         in_op,
  input  wire logic signed [31:0] in_a_num,
  input  wire logic [30:0]        in_a_den,
  input  wire logic signed [31:0] in_b_num,
  input  wire logic [30:0]        in_b_den,
  input  wire logic               out_ready,
  output logic                    out_valid,
  output logic signed [31:0]      out_res_num,
  output logic [30:0]             out_res_den,
  output logic                    out_less,
  output logic                    out_equal,
  output logic                    out_greater,
  output logic [1:0]              out_status
);

  localparam logic [63:0] LIM = (64'd1 << (WORD_BITS - 1)) - 64'd1;

  logic [2:0]         op_r;
  logic signed [31:0] an_r, bn_r;
  logic [30:0]        ad_r, bd_r;
  logic signed [63:0] lhs_r, rhs_r, t_r, s_r;
  logic               lt_r, eq_r, gt_r;
  logic [63:0]        ms_r, mt_r, u_r, v_r, g_r, q_r, rem_r;
  logic [5:0]         k_r, cnt_r;
  logic               neg_r, zs_r, zt_r;
  logic               out_valid_r;
  logic signed [31:0] res_num_r;
  logic [30:0]        res_den_r;
  logic               less_r, equal_r, greater_r;
  logic [1:0]         status_r;

  logic signed [32:0] ma, mb;
  logic signed [65:0] prod;
  logic signed [63:0] s_nxt;
  logic               arith;
  logic [64:0]        rtry;
  logic [64:0]        rdif;
  logic [63:0]        q_nxt, rem_nxt;
  logic [63:0]        s_mag, t_mag;
  logic signed [31:0] res_num_nxt;
  logic [30:0]        res_den_nxt;
  logic [1:0]         status_nxt;

  assign arith = (op_r == rau_pkg::OP_ADD) || (op_r == rau_pkg::OP_SUB) ||
                 (op_r == rau_pkg::OP_MUL) || (op_r == rau_pkg::OP_DIV);

  always_comb begin
    unique case (cmd.mul_sel)
      rau_pkg::MS_LHS: begin ma = 33'(an_r); mb = $signed({2'b00, bd_r}); end
      rau_pkg::MS_RHS: begin ma = 33'(bn_r); mb = $signed({2'b00, ad_r}); end
      rau_pkg::MS_T: begin
        ma = $signed({2'b00, ad_r});
        mb = (op_r == rau_pkg::OP_DIV) ? 33'(bn_r) : $signed({2'b00, bd_r});
      end
      rau_pkg::MS_S: begin ma = 33'(an_r); mb = 33'(bn_r); end
      default: begin ma = '0; mb = '0; end
    endcase
    prod = ma * mb;
  end

  always_comb begin
    unique case (op_r)
      rau_pkg::OP_ADD: s_nxt = lhs_r + rhs_r;
      rau_pkg::OP_SUB: s_nxt = lhs_r - rhs_r;
      rau_pkg::OP_MUL: s_nxt = s_r;
      default:         s_nxt = lhs_r;
    endcase
  end

  assign s_mag = s_r[63] ? 64'(-s_r) : 64'(s_r);
  assign t_mag = t_r[63] ? 64'(-t_r) : 64'(t_r);

  assign rtry    = {rem_r, q_r[63]};
  assign rdif    = rtry - {1'b0, g_r};
  assign q_nxt   = {q_r[62:0], ~rdif[64]};
  assign rem_nxt = rdif[64] ? rtry[63:0] : rdif[63:0];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r <= in_op;
      an_r <= in_a_num;
      ad_r <= in_a_den;
      bn_r <= in_b_num;
      bd_r <= in_b_den;
    end
    if (cmd.mul_en) begin
      unique case (cmd.mul_sel)
        rau_pkg::MS_LHS: lhs_r <= prod[63:0];
        rau_pkg::MS_RHS: rhs_r <= prod[63:0];
        rau_pkg::MS_T:   t_r   <= prod[63:0];
        rau_pkg::MS_S:   s_r   <= prod[63:0];
        default: ;
      endcase
    end
    if (cmd.form) begin
      s_r  <= s_nxt;
      lt_r <= lhs_r < rhs_r;
      eq_r <= lhs_r == rhs_r;
      gt_r <= lhs_r > rhs_r;
    end
    if (cmd.sign) begin
      neg_r <= s_r[63] ^ t_r[63];
      zs_r  <= s_r == 64'sd0;
      zt_r  <= t_r == 64'sd0;
      ms_r  <= s_mag;
      mt_r  <= t_mag;
      u_r   <= s_mag;
      v_r   <= t_mag;
      k_r   <= '0;
    end
    if (cmd.gcd_step) begin
      priority if (!u_r[0] && !v_r[0]) begin
        u_r <= u_r >> 1;
        v_r <= v_r >> 1;
        k_r <= k_r + 6'd1;
      end else if (!u_r[0]) begin
        u_r <= u_r >> 1;
      end else if (!v_r[0]) begin
        v_r <= v_r >> 1;
      end else if (u_r >= v_r) begin
        u_r <= u_r - v_r;
      end else begin
        v_r <= v_r - u_r;
      end
    end
    if (cmd.gcd_fin) begin
      g_r   <= (u_r | v_r) << k_r;
      q_r   <= ms_r;
      rem_r <= '0;
      cnt_r <= '0;
    end
    if (cmd.div_step) begin
      cnt_r <= cnt_r + 6'd1;
      if (cmd.div_end_s) begin
        ms_r  <= q_nxt;
        q_r   <= mt_r;
        rem_r <= '0;
      end else begin
        q_r   <= q_nxt;
        rem_r <= rem_nxt;
      end
      if (cmd.div_end_t) mt_r <= q_nxt;
    end
    if (cmd.out_load) begin
      res_num_r <= res_num_nxt;
      res_den_r <= res_den_nxt;
      status_r  <= status_nxt;
      less_r    <= lt_r;
      equal_r   <= eq_r;
      greater_r <= gt_r;
    end
  end

  always_comb begin
    res_num_nxt = '0;
    res_den_nxt = '0;
    status_nxt  = rau_pkg::ST_OK;
    if (arith) begin
      priority if (zt_r) begin
        status_nxt = rau_pkg::ST_ZDEN;
      end else if (zs_r) begin
        res_den_nxt = 31'd1;
      end else if ((ms_r > LIM) || (mt_r > LIM)) begin
        status_nxt = rau_pkg::ST_OVF;
      end else begin
        res_num_nxt = neg_r ? 32'(-ms_r[31:0]) : ms_r[31:0];
        res_den_nxt = mt_r[30:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_comb begin
    sts.arith    = arith;
    sts.zs       = s_r == 64'sd0;
    sts.zt       = t_r == 64'sd0;
    sts.gcd_done = (u_r == 64'd0) || (v_r == 64'd0);
    sts.div_last = cnt_r == 6'd63;
    sts.out_free = !out_valid_r || out_ready;
  end

  assign out_valid   = out_valid_r;
  assign out_res_num = res_num_r;
  assign out_res_den = res_den_r;
  assign out_less    = less_r;
  assign out_equal   = equal_r;
  assign out_greater = greater_r;
  assign out_status  = status_r;

endmodule
`default_nettype wire

// ----- rtl/rau_ctrl.sv -----
// Controller: sequences multiplier passes, gcd and the two divisions.
// Depends on rau_pkg.
`default_nettype none
module rau_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire rau_pkg::sts_t sts,
  output rau_pkg::cmd_t      cmd
);

  rau_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= rau_pkg::S_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rau_pkg::S_IDLE:  if (in_valid) state_nxt = rau_pkg::S_MUL_L;
      rau_pkg::S_MUL_L: state_nxt = rau_pkg::S_MUL_R;
      rau_pkg::S_MUL_R: state_nxt = rau_pkg::S_MUL_T;
      rau_pkg::S_MUL_T: state_nxt = rau_pkg::S_MUL_S;
      rau_pkg::S_MUL_S: state_nxt = rau_pkg::S_FORM;
      rau_pkg::S_FORM:  state_nxt = sts.arith ? rau_pkg::S_SIGN : rau_pkg::S_FIN;
      rau_pkg::S_SIGN:  state_nxt = (sts.zs || sts.zt) ? rau_pkg::S_FIN : rau_pkg::S_GCD;
      rau_pkg::S_GCD:   if (sts.gcd_done) state_nxt = rau_pkg::S_DIVS;
      rau_pkg::S_DIVS:  if (sts.div_last) state_nxt = rau_pkg::S_DIVT;
      rau_pkg::S_DIVT:  if (sts.div_last) state_nxt = rau_pkg::S_FIN;
      rau_pkg::S_FIN:   if (sts.out_free) state_nxt = rau_pkg::S_IDLE;
      default:          state_nxt = rau_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      rau_pkg::S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      rau_pkg::S_MUL_L: begin cmd.mul_en = 1'b1; cmd.mul_sel = rau_pkg::MS_LHS; end
      rau_pkg::S_MUL_R: begin cmd.mul_en = 1'b1; cmd.mul_sel = rau_pkg::MS_RHS; end
      rau_pkg::S_MUL_T: begin cmd.mul_en = 1'b1; cmd.mul_sel = rau_pkg::MS_T; end
      rau_pkg::S_MUL_S: begin cmd.mul_en = 1'b1; cmd.mul_sel = rau_pkg::MS_S; end
      rau_pkg::S_FORM:  cmd.form = 1'b1;
      rau_pkg::S_SIGN:  cmd.sign = 1'b1;
      rau_pkg::S_GCD: begin
        cmd.gcd_step = !sts.gcd_done;
        cmd.gcd_fin  = sts.gcd_done;
      end
      rau_pkg::S_DIVS: begin
        cmd.div_step  = 1'b1;
        cmd.div_end_s = sts.div_last;
      end
      rau_pkg::S_DIVT: begin
        cmd.div_step  = 1'b1;
        cmd.div_end_t = sts.div_last;
      end
      rau_pkg::S_FIN:   cmd.out_load = sts.out_free;
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ----- rtl/rational_arithmetic_unit.sv -----
// Top level of the rational arithmetic unit: controller plus datapath.
// Depends on rau_pkg, rau_ctrl, rau_datapath.
//
// Usage: one beat on the in_ channel carries an op and two reduced
// fractions a_num/a_den and b_num/b_den. One beat per item comes back on
// the out_ channel: the reduced result (sign on the numerator), the
// less/equal/greater flags and a status (ok, zero denominator, overflow).
// Compare-only items skip the sign, gcd and division steps; items with a
// zero numerator or denominator skip the gcd and the divisions. Others
// run the binary gcd on the 64-bit magnitudes, then two 64-step restoring
// divisions by the gcd. One multiplier is shared over four passes.
// Items are processed one at a time; in_ready is high only when idle.
// The result sits in an output register; a stalled receiver holds the
// finished beat, and the next item may be taken meanwhile but waits
// before its own result is loaded.
// Reset (synchronous, rst_n low) returns the controller to idle and
// drops out_valid.
`default_nettype none
module rational_arithmetic_unit #(
  parameter int WORD_BITS = 32
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [2:0]         in_op,
  input  wire logic signed [31:0] in_a_num,
  input  wire logic [30:0]        in_a_den,
  input  wire logic signed [31:0] in_b_num,
  input  wire logic [30:0]        in_b_den,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      out_res_num,
  output logic [30:0]             out_res_den,
  output logic                    out_less,
  output logic                    out_equal,
  output logic                    out_greater,
  output logic [1:0]              out_status
);

  rau_pkg::cmd_t cmd;
  rau_pkg::sts_t sts;

  rau_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  rau_datapath #(.WORD_BITS(WORD_BITS)) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .in_op       (in_op),
    .in_a_num    (in_a_num),
    .in_a_den    (in_a_den),
    .in_b_num    (in_b_num),
    .in_b_den    (in_b_den),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .out_res_num (out_res_num),
    .out_res_den (out_res_den),
    .out_less    (out_less),
    .out_equal   (out_equal),
    .out_greater (out_greater),
    .out_status  (out_status)
  );

endmodule
`default_nettype wire

// ----- rtl/rau_checker.sv -----
// Port-level assertions for rational_arithmetic_unit, bound to the top level.
// Depends on rau_pkg for the status codes.
`default_nettype none
module rau_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] out_res_num,
  input wire logic [30:0] out_res_den,
  input wire logic        out_less,
  input wire logic        out_equal,
  input wire logic        out_greater,
  input wire logic [1:0]  out_status
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_res_num) && $stable(out_res_den))
    else $error("result beat changed while stalled");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while busy");

  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $onehot({out_less, out_equal, out_greater}))
    else $error("compare flags not exclusive");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != rau_pkg::ST_OK |->
      out_res_num == 32'd0 && out_res_den == 31'd0)
    else $error("error result not zeroed");

  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == rau_pkg::ST_OK) || (out_status == rau_pkg::ST_ZDEN) ||
                  (out_status == rau_pkg::ST_OVF))
    else $error("undefined status");

endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .out_res_num (out_res_num),
  .out_res_den (out_res_den),
  .out_less    (out_less),
  .out_equal   (out_equal),
  .out_greater (out_greater),
  .out_status  (out_status)
);
`default_nettype wire

// ----- bench/rational_arithmetic_unit_tb.sv -----
// Testbench for rational_arithmetic_unit: directed and random fraction pairs,
// results predicted in a scoreboard class and checked beat by beat.
// Depends on rau_pkg and the rational_arithmetic_unit RTL.
module rational_arithmetic_unit_tb;

  localparam logic [2:0] OP_CMP = 3'd4;
  localparam int N_RANDOM = 1530;
  localparam longint CYCLE_LIMIT = 5000000;
  localparam longint unsigned MAG_MAX = 64'h7fff_ffff;

  typedef struct {
    logic signed [31:0] num;
    logic [30:0]        den;
    logic               lt;
    logic               eq;
    logic               gt;
    logic [1:0]         status;
  } rat_result_t;

  class rat_scoreboard;
    rat_result_t pending_q[$];
    int errors;

    function rat_result_t predict_rational(logic [2:0] op, logic signed [31:0] an,
                                           logic [30:0] ad, logic signed [31:0] bn,
                                           logic [30:0] bd);
      rat_result_t r;
      longint lhs, rhs, s, t, x, y, m;
      longint unsigned ms, mt;
      logic neg;
      lhs = longint'(an) * longint'(bd);
      rhs = longint'(bn) * longint'(ad);
      r.lt = lhs < rhs;
      r.eq = lhs == rhs;
      r.gt = lhs > rhs;
      r.num = '0;
      r.den = '0;
      r.status = rau_pkg::ST_OK;
      if (op <= rau_pkg::OP_DIV) begin
        t = longint'(ad) * longint'(bd);
        case (op)
          rau_pkg::OP_ADD: s = lhs + rhs;
          rau_pkg::OP_SUB: s = lhs - rhs;
          rau_pkg::OP_MUL: s = longint'(an) * longint'(bn);
          default: begin
            s = lhs;
            t = longint'(ad) * longint'(bn);
          end
        endcase
        if (t == 0) begin
          r.status = rau_pkg::ST_ZDEN;
        end else begin
          neg = (s < 0) != (t < 0);
          ms = (s < 0) ? -s : s;
          mt = (t < 0) ? -t : t;
          if (ms == 0) begin
            neg = 1'b0;
            mt = 1;
          end else begin
            x = ms;
            y = mt;
            while (y != 0) begin
              m = longint'(longint'(x) % longint'(y));
              x = y;
              y = m;
            end
            ms = ms / longint'(unsigned'(x));
            mt = mt / longint'(unsigned'(x));
          end
          if (ms > MAG_MAX || mt > MAG_MAX) begin
            r.status = rau_pkg::ST_OVF;
          end else begin
            r.num = neg ? -ms[31:0] : ms[31:0];
            r.den = mt[30:0];
          end
        end
      end
      return r;
    endfunction

    function void note_input(logic [2:0] op, logic signed [31:0] an, logic [30:0] ad,
                             logic signed [31:0] bn, logic [30:0] bd);
      pending_q.push_back(predict_rational(op, an, ad, bn, bd));
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_result(rat_result_t got);
      rat_result_t e;
      if (pending_q.size() == 0) begin
        report("result beat with nothing expected");
        return;
      end
      e = pending_q.pop_front();
      if (got.num !== e.num) report($sformatf("res_num %0d, want %0d", got.num, e.num));
      if (got.den !== e.den) report($sformatf("res_den %0d, want %0d", got.den, e.den));
      if (got.lt !== e.lt) report($sformatf("less %b, want %b", got.lt, e.lt));
      if (got.eq !== e.eq) report($sformatf("equal %b, want %b", got.eq, e.eq));
      if (got.gt !== e.gt) report($sformatf("greater %b, want %b", got.gt, e.gt));
      if (got.status !== e.status)
        report($sformatf("status %0d, want %0d", got.status, e.status));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [2:0] in_op = '0;
  logic signed [31:0] in_a_num = '0;
  logic [30:0] in_a_den = 31'd1;
  logic signed [31:0] in_b_num = '0;
  logic [30:0] in_b_den = 31'd1;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] out_res_num;
  logic [30:0] out_res_den;
  logic out_less, out_equal, out_greater;
  logic [1:0] out_status;

  rat_scoreboard board;
  bit long_hold_req = 0;
  bit calm_mode = 0;
  longint cycles = 0;

  rational_arithmetic_unit u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_op(in_op),
    .in_a_num(in_a_num), .in_a_den(in_a_den), .in_b_num(in_b_num), .in_b_den(in_b_den),
    .out_valid(out_valid), .out_ready(out_ready), .out_res_num(out_res_num),
    .out_res_den(out_res_den), .out_less(out_less), .out_equal(out_equal),
    .out_greater(out_greater), .out_status(out_status)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function int draw_gap();
    if (calm_mode) return 0;
    return $urandom_range(0, 13);
  endfunction

  // sender: called at the edge where the previous beat was accepted
  task send_item(logic [2:0] op, logic signed [31:0] an, logic [30:0] ad,
                 logic signed [31:0] bn, logic [30:0] bd);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_a_num <= an;
    in_a_den <= ad;
    in_b_num <= bn;
    in_b_den <= bd;
    do @(posedge clk); while (!in_ready);
    board.note_input(op, an, ad, bn, bd);
  endtask

  task wait_drained();
    in_valid <= 1'b0;
    while (board.pending_q.size() != 0) @(posedge clk);
  endtask

  function logic signed [31:0] rand_num();
    case ($urandom_range(0, 6))
      0, 1: return $urandom();
      2: return $signed($urandom_range(0, 40)) - 20;
      3: return $urandom_range(0, 1) ? 32'sh7fff_ffff : -32'sh7fff_ffff;
      4: return 32'sh8000_0000;
      5: return $signed(32'd1 << $urandom_range(0, 30)) * ($urandom_range(0, 1) ? 1 : -1);
      default: return $signed($urandom_range(0, 2000)) - 1000;
    endcase
  endfunction

  function logic [30:0] rand_den();
    case ($urandom_range(0, 7))
      0, 1: return 31'($urandom());
      2: return 31'($urandom_range(1, 20));
      3: return 31'h7fff_ffff;
      4: return 31'd1 << $urandom_range(0, 30);
      5: return $urandom_range(0, 30) == 0 ? 31'd0 : 31'd1;
      default: return 31'($urandom_range(1, 5000));
    endcase
  endfunction

  // receiver
  initial begin : receiver
    int stall;
    rat_result_t got;
    @(posedge rst_n);
    forever begin
      stall = calm_mode ? 0 : $urandom_range(0, 13);
      if (long_hold_req) begin
        long_hold_req = 0;
        stall = 3000;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      got.num = out_res_num;
      got.den = out_res_den;
      got.lt = out_less;
      got.eq = out_equal;
      got.gt = out_greater;
      got.status = out_status;
      board.check_result(got);
    end
  end

  initial begin : stimulus
    int k;
    board = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed: every op, extremes, zero and overflow cases
    send_item(rau_pkg::OP_ADD, 32'sd1, 31'd2, 32'sd1, 31'd3);
    send_item(rau_pkg::OP_SUB, 32'sd1, 31'd2, 32'sd1, 31'd2);
    send_item(rau_pkg::OP_MUL, -32'sd3, 31'd4, 32'sd2, 31'd9);
    send_item(rau_pkg::OP_DIV, 32'sd5, 31'd7, -32'sd10, 31'd21);
    send_item(OP_CMP, 32'sd1, 31'd3, 32'sd2, 31'd5);
    send_item(3'd5, -32'sd7, 31'd1, 32'sd7, 31'd1);
    send_item(3'd6, 32'sd4, 31'd6, 32'sd2, 31'd3);
    send_item(3'd7, 32'sd9, 31'd2, 32'sd1, 31'd2);
    send_item(rau_pkg::OP_DIV, 32'sd3, 31'd4, 32'sd0, 31'd1);
    send_item(rau_pkg::OP_ADD, 32'sd3, 31'd0, 32'sd1, 31'd2);
    send_item(rau_pkg::OP_MUL, 32'sd3, 31'd5, 32'sd1, 31'd0);
    send_item(rau_pkg::OP_MUL, 32'sd0, 31'd5, -32'sd9, 31'd4);
    send_item(rau_pkg::OP_ADD, 32'sh7fff_ffff, 31'd1, 32'sd1, 31'd1);
    send_item(rau_pkg::OP_SUB, -32'sh7fff_ffff, 31'd1, 32'sd1, 31'd1);
    send_item(rau_pkg::OP_MUL, 32'sh7fff_ffff, 31'd1, 32'sh7fff_ffff, 31'd1);
    send_item(rau_pkg::OP_DIV, 32'sd1, 31'h7fff_ffff, 32'sd1, 31'h7fff_ffff);
    send_item(rau_pkg::OP_ADD, 32'sd1, 31'h7fff_ffff, 32'sd1, 31'h7fff_fffe);
    send_item(rau_pkg::OP_SUB, 32'sh8000_0000, 31'd1, 32'sd0, 31'd1);
    send_item(rau_pkg::OP_DIV, -32'sh7fff_ffff, 31'd3, -32'sh7fff_ffff, 31'h7fff_ffff);
    send_item(rau_pkg::OP_MUL, 32'shffff_ffff, 31'h7fff_ffff, 32'sh8000_0000,
              31'h5555_5555);
    send_item(OP_CMP, 32'sh7fff_ffff, 31'h7fff_ffff, 32'sh7fff_ffff, 31'h7fff_ffff);
    for (k = 0; k < N_RANDOM; k++) begin
      if (k == 300) long_hold_req = 1;
      if (k == 900) wait_drained();
      if (k % 200 == 100) calm_mode = 1;
      if (k % 200 == 140) calm_mode = 0;
      send_item($urandom_range(0, 9) == 0 ? 3'($urandom_range(4, 7)) : 3'($urandom_range(0, 3)),
                rand_num(), rand_den(), rand_num(), rand_den());
    end
    in_valid <= 1'b0;
    calm_mode = 0;
    wait_drained();
    repeat (400) @(posedge clk);
    if (board.errors == 0 && board.pending_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      if (board.pending_q.size() != 0)
        board.report($sformatf("%0d results never came", board.pending_q.size()));
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule

// ----- sim.f -----
rtl/rau_pkg.sv
rtl/rau_datapath.sv
rtl/rau_ctrl.sv
rtl/rational_arithmetic_unit.sv
rtl/rau_checker.sv
bench/rational_arithmetic_unit_tb.sv
